### design/motion_sensor_qualifier_hold_fsm_macros.svh
// Assertion macros used by the checker of the motion qualifier.
`ifndef MOTION_SENSOR_QUALIFIER_HOLD_FSM_MACROS_SVH
`define MOTION_SENSOR_QUALIFIER_HOLD_FSM_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define MSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked while reset is held.
`define MSQ_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/msq_pkg.sv
package msq_pkg;

  // Default vote window length
  localparam int MAX_VOTE_DEPTH_DEF = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_DEPTH  = 2'd2;

  // Register reset values
  localparam int FD_W = 4;
  localparam logic [31:0]     HOLD_TIME_RST     = 32'd2000;
  localparam logic [31:0]     DEBOUNCE_TIME_RST = 32'd50;
  localparam logic [FD_W-1:0] FILTER_DEPTH_RST  = 4'd3;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Machine state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TRIG   = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  typedef struct packed {
    logic        operation;
    logic        raw_sample;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  fsm_state;
    logic        motion_detected;
    logic        stable_level;
    logic        trigger_event;
    logic        active_event;
    logic        idle_event;
    logic [31:0] trigger_count;
    logic [31:0] last_active_ms;
    logic [31:0] ms_since_trigger;
  } out_t;

  // Control from the sequencer to the vote window
  typedef struct packed {
    logic push;
    logic clear;
    logic sample;
  } vote_ctl_t;

endpackage

### design/msq_vote.sv
module msq_vote #(
  parameter int MAX_VOTE_DEPTH = msq_pkg::MAX_VOTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  msq_pkg::vote_ctl_t         ctl,
  input  logic [msq_pkg::FD_W-1:0]   filter_depth,
  output logic                       vote
);
  import msq_pkg::*;

  localparam int PTR_W   = (MAX_VOTE_DEPTH > 1) ? $clog2(MAX_VOTE_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(MAX_VOTE_DEPTH + 1);
  localparam int CW      = (DEPTH_W > FD_W) ? DEPTH_W : FD_W;
  localparam int NUM_W   = PTR_W + 1;

  logic [MAX_VOTE_DEPTH-1:0] window;
  logic [MAX_VOTE_DEPTH-1:0] window_next;
  logic [PTR_W-1:0]          ptr;
  logic [PTR_W-1:0]          ptr_next;
  logic [CW-1:0]             fd_ext;
  logic [CW-1:0]             depth;
  logic [CW-1:0]             ones;
  logic [NUM_W-1:0]          num;
  logic [CW:0]               rem;

  // Effective depth: zero acts as one, clipped to the window size
  always_comb begin
    fd_ext = CW'(filter_depth);
    if (fd_ext == '0) begin
      depth = CW'(1);
    end else if (fd_ext > CW'(MAX_VOTE_DEPTH)) begin
      depth = CW'(MAX_VOTE_DEPTH);
    end else begin
      depth = fd_ext;
    end
  end

  // Window with the new sample written at the pointer
  always_comb begin
    window_next      = window;
    window_next[ptr] = ctl.sample;
  end

  // Count of ones over the first depth entries, then majority
  always_comb begin
    ones = '0;
    for (int i = 0; i < MAX_VOTE_DEPTH; i++) begin
      if (CW'(i) < depth) begin
        ones = ones + CW'(window_next[i]);
      end
    end
    vote = (ones > (depth >> 1));
  end

  // Pointer advance modulo depth: short restoring remainder over PTR_W + 1 bits
  always_comb begin
    num = NUM_W'(ptr) + NUM_W'(1);
    rem = '0;
    for (int i = NUM_W - 1; i >= 0; i--) begin
      rem = {rem[CW-1:0], num[i]};
      if (rem >= {1'b0, depth}) begin
        rem = rem - {1'b0, depth};
      end
    end
    ptr_next = PTR_W'(rem);
  end

  // Window and pointer registers
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      window <= '0;
      ptr    <= '0;
    end else if (ctl.push) begin
      window <= window_next;
      ptr    <= ptr_next;
    end
  end

endmodule

### design/motion_sensor_qualifier_hold_fsm.sv
// Motion qualifier: majority vote, time debounce and hold state machine.
// The request loads into the input register on acceptance and the result
// register loads when the request advances; one request per cycle is
// sustained while out_ready stays high. The vote, debounce and state
// update are combinational between the two registers.
// Reset (synchronous): registers to defaults, state idle, pipeline empty.
module motion_sensor_qualifier_hold_fsm #(
  parameter int MAX_VOTE_DEPTH = msq_pkg::MAX_VOTE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  msq_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output msq_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [msq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import msq_pkg::*;

  // Configuration
  logic [31:0]     hold_time;
  logic [31:0]     debounce_time;
  logic [FD_W-1:0] filter_depth;

  // Input stage
  logic held;
  in_t  req;
  logic advance;

  // Qualifier state
  logic        stable_bit,  stable_bit_next;
  logic [31:0] change_time, change_time_next;
  logic [1:0]  machine_state, machine_state_next;
  logic [31:0] trigger_time, trigger_time_next;
  logic [31:0] hold_start_time, hold_start_time_next;
  logic [31:0] trigger_total, trigger_total_next;
  logic [31:0] last_active_duration, last_active_duration_next;

  logic       ev_trig, ev_act, ev_idle;
  logic       vote;
  vote_ctl_t  vctl;
  out_t       result;

  // Handshake: request moves on when the result register is free or draining
  assign advance   = held && (!out_valid || out_ready);
  assign in_ready  = !held || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time     <= HOLD_TIME_RST;
      debounce_time <= DEBOUNCE_TIME_RST;
      filter_depth  <= FILTER_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_TIME:     hold_time     <= cfg_data;
        REG_DEBOUNCE_TIME: debounce_time <= cfg_data;
        REG_FILTER_DEPTH:  filter_depth  <= cfg_data[FD_W-1:0];
        default: ;
      endcase
    end
  end

  // Vote window
  assign vctl.push   = advance && (req.operation == OP_SAMPLE);
  assign vctl.clear  = advance && (req.operation == OP_CLEAR);
  assign vctl.sample = req.raw_sample;

  msq_vote #(
    .MAX_VOTE_DEPTH(MAX_VOTE_DEPTH)
  ) u_vote (
    .clk          (clk),
    .rst          (rst),
    .ctl          (vctl),
    .filter_depth (filter_depth),
    .vote         (vote)
  );

  // Debounce and state machine
  always_comb begin
    stable_bit_next           = stable_bit;
    change_time_next          = change_time;
    machine_state_next        = machine_state;
    trigger_time_next         = trigger_time;
    hold_start_time_next      = hold_start_time;
    trigger_total_next        = trigger_total;
    last_active_duration_next = last_active_duration;
    ev_trig = 1'b0;
    ev_act  = 1'b0;
    ev_idle = 1'b0;
    if (req.operation == OP_CLEAR) begin
      machine_state_next        = ST_IDLE;
      stable_bit_next           = 1'b0;
      trigger_time_next         = '0;
      hold_start_time_next      = '0;
      last_active_duration_next = '0;
      change_time_next          = req.now_ms;
    end else begin
      if (vote != stable_bit) begin
        if ((req.now_ms - change_time) >= debounce_time) begin
          stable_bit_next  = vote;
          change_time_next = req.now_ms;
        end
      end else begin
        change_time_next = req.now_ms;
      end

      unique case (machine_state)
        ST_IDLE: begin
          if (stable_bit_next) begin
            machine_state_next = ST_TRIG;
            trigger_time_next  = req.now_ms;
            trigger_total_next = trigger_total + 32'd1;
            ev_trig            = 1'b1;
          end
        end
        ST_TRIG: begin
          machine_state_next = ST_ACTIVE;
          ev_act             = 1'b1;
        end
        ST_ACTIVE: begin
          if (stable_bit_next) begin
            ev_act = 1'b1;
          end else begin
            machine_state_next        = ST_HOLD;
            hold_start_time_next      = req.now_ms;
            last_active_duration_next = req.now_ms - trigger_time;
          end
        end
        ST_HOLD: begin
          // retrigger wins over expiry
          if (stable_bit_next) begin
            machine_state_next = ST_ACTIVE;
            trigger_total_next = trigger_total + 32'd1;
            ev_trig            = 1'b1;
          end else if ((req.now_ms - hold_start_time) >= hold_time) begin
            machine_state_next = ST_IDLE;
            ev_idle            = 1'b1;
          end else begin
            ev_act = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result assembly
  always_comb begin
    result.fsm_state        = machine_state_next;
    result.motion_detected  = (machine_state_next != ST_IDLE);
    result.stable_level     = stable_bit_next;
    result.trigger_event    = ev_trig;
    result.active_event     = ev_act;
    result.idle_event       = ev_idle;
    result.trigger_count    = trigger_total_next;
    result.last_active_ms   = last_active_duration_next;
    result.ms_since_trigger = (trigger_time_next == '0) ? '0
                                                        : (req.now_ms - trigger_time_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held                 <= 1'b0;
      out_valid            <= 1'b0;
      stable_bit           <= 1'b0;
      change_time          <= '0;
      machine_state        <= ST_IDLE;
      trigger_time         <= '0;
      hold_start_time      <= '0;
      trigger_total        <= '0;
      last_active_duration <= '0;
    end else begin
      if (in_ready) begin
        held <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        stable_bit           <= stable_bit_next;
        change_time          <= change_time_next;
        machine_state        <= machine_state_next;
        trigger_time         <= trigger_time_next;
        hold_start_time      <= hold_start_time_next;
        trigger_total        <= trigger_total_next;
        last_active_duration <= last_active_duration_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

### design/msq_checker.sv
`include "motion_sensor_qualifier_hold_fsm_macros.svh"

module msq_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input msq_pkg::out_t out_data
);
  import msq_pkg::*;

  // A stalled result holds
  `MSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Motion flag follows the state
  `MSQ_ASSERT_IMPL(a_motion_flag, out_valid, out_data.motion_detected == (out_data.fsm_state != ST_IDLE), "motion flag disagrees with state")

  // A trigger always lands in triggered or active, with a high stable level
  `MSQ_ASSERT_IMPL(a_trig_state, out_valid && out_data.trigger_event, out_data.stable_level && ((out_data.fsm_state == ST_TRIG) || (out_data.fsm_state == ST_ACTIVE)), "trigger outside triggered or active")

  // Expiry lands in idle with a low level, and no other event comes with it
  `MSQ_ASSERT_IMPL(a_idle_state, out_valid && out_data.idle_event, !out_data.stable_level && (out_data.fsm_state == ST_IDLE) && $onehot0({out_data.trigger_event, out_data.active_event, out_data.idle_event}), "bad idle event")

  // Nothing comes out just after reset
  `MSQ_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind motion_sensor_qualifier_hold_fsm msq_checker u_msq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
